### rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property under clock, disabled while reset is low
`define RDF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rdf assertion failed");

// antecedent in one cycle, consequent in the next
`define RDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdf assertion failed");

`endif

### rtl/rdf_pkg.sv
// ----------------------------------------------------------------------------
// rdf_pkg
// Types and constants of the raw result duplicate filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rdf_pkg;

    localparam int DEF_ENTRIES = 32;

    localparam int CMD_W  = 1;
    localparam int JOB_W  = 8;
    localparam int WORD_W = 32;

    localparam logic [CMD_W-1:0] CMD_CHECK = 1'b0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic [JOB_W-1:0]  job_id;
        logic [WORD_W-1:0] nonce;
        logic [WORD_W-1:0] ver_roll;
        logic [WORD_W-1:0] hist_rev;
    } t_key;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INS,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

### rtl/rdf_if.sv
// ----------------------------------------------------------------------------
// rdf_in_if / rdf_out_if
// Valid/ready channels of the duplicate filter: check items in, verdicts out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdf_in_if;
    import rdf_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [JOB_W-1:0]    job_id;
    logic [WORD_W-1:0]   nonce;
    logic [WORD_W-1:0]   ver_roll;
    logic [WORD_W-1:0]   hist_rev;

    modport source (
        output valid, cmd, job_id, nonce, ver_roll, hist_rev,
        input  ready
    );
    modport sink (
        input  valid, cmd, job_id, nonce, ver_roll, hist_rev,
        output ready
    );
endinterface

interface rdf_out_if;
    logic valid;
    logic ready;
    logic is_new;

    modport source (output valid, is_new, input ready);
    modport sink (input valid, is_new, output ready);
endinterface

`default_nettype wire

### rtl/raw_result_duplicate_filter_top.sv
// ----------------------------------------------------------------------------
// raw_result_duplicate_filter_top
// Recent-result duplicate filter over a ring of stored keys.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one item per handshake: cmd selects check or clear. A check
//   item gives one result on o_out: is_new = 1 when the key was unseen and
//   has been stored, 0 when it matched a stored key. A clear item empties
//   the filter and gives no result. A check walks the filled entries
//   through the single read port of the key memory, one entry per cycle,
//   stopping at the first match. A miss then stores the key in the insert
//   state; on an empty filter the walk is skipped. The verdict waits in the
//   done state until the output register is free. A check is accepted
//   again the cycle after the result moves into the output register. Keys
//   go in at a wrapping insert pointer, oldest first. Reset empties the
//   filter (fill count and pointer to zero); the key memory itself is not
//   cleared. While o_out is stalled the result is held and one more
//   finished check waits inside; further items are not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module raw_result_duplicate_filter_top #(
    parameter int ENTRIES = rdf_pkg::DEF_ENTRIES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rdf_in_if.sink     i_in,
    rdf_out_if.source  o_out
);
    import rdf_pkg::*;

    localparam int ADDR_W = $clog2(ENTRIES);
    localparam int FILL_W = $clog2(ENTRIES + 1);

    t_state              r_state, n_state;
    t_key                r_key;
    t_key                rd_data;
    logic [ADDR_W-1:0]   r_ptr;
    logic [ADDR_W-1:0]   r_addr;
    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   fill_m1;
    logic                r_issue_done;
    logic                r_rd_vld;
    logic                r_rd_last;
    logic                r_is_new;
    logic                r_out_vld;
    logic                r_out_is_new;

    logic                in_ready;
    logic                in_acc;
    logic                is_check;
    logic                issue;
    logic                last_addr;
    logic                hit;
    logic                miss_end;
    logic                mem_we;
    logic                out_free;

    assign in_acc    = i_in.valid && in_ready;
    assign is_check  = (i_in.cmd == CMD_CHECK);
    assign fill_m1   = r_fill - FILL_W'(1);
    assign last_addr = (r_addr == fill_m1[ADDR_W-1:0]);

    assign i_in.ready   = in_ready;
    assign o_out.valid  = r_out_vld;
    assign o_out.is_new = r_out_is_new;

    rdf_key_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_ptr),
        .i_wdata (r_key),
        .i_re    (issue),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && is_check) begin
                    n_state = (r_fill == '0) ? ST_INS : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    n_state = ST_DONE;
                end else if (miss_end) begin
                    n_state = ST_INS;
                end
            end
            ST_INS: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        in_ready = (r_state == ST_IDLE);
        issue    = (r_state == ST_SCAN) && !r_issue_done;
        mem_we   = (r_state == ST_INS);
        hit      = (r_state == ST_SCAN) && r_rd_vld && (rd_data == r_key);
        miss_end = (r_state == ST_SCAN) && r_rd_vld && r_rd_last && !hit;
        out_free = !r_out_vld || o_out.ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ptr        <= '0;
            r_fill       <= '0;
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_rd_last    <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= issue;
            r_rd_last <= issue && last_addr;

            if (in_acc && !is_check) begin
                r_ptr  <= '0;
                r_fill <= '0;
            end else if (mem_we) begin
                r_ptr <= (r_ptr == ADDR_W'(ENTRIES - 1)) ? '0 : r_ptr + ADDR_W'(1);
                if (r_fill != FILL_W'(ENTRIES)) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end

            if (in_acc) begin
                r_issue_done <= 1'b0;
            end else if (issue && last_addr) begin
                r_issue_done <= 1'b1;
            end

            if (r_state == ST_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key.job_id   <= i_in.job_id;
            r_key.nonce    <= i_in.nonce;
            r_key.ver_roll <= i_in.ver_roll;
            r_key.hist_rev <= i_in.hist_rev;
            r_addr         <= '0;
        end else if (issue && !last_addr) begin
            r_addr <= r_addr + ADDR_W'(1);
        end

        if (hit) begin
            r_is_new <= 1'b0;
        end else if (mem_we) begin
            r_is_new <= 1'b1;
        end

        if (r_state == ST_DONE && out_free) begin
            r_out_is_new <= r_is_new;
        end
    end

endmodule

`default_nettype wire

### rtl/rdf_key_store.sv
// ----------------------------------------------------------------------------
// rdf_key_store
// Key memory: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rdf_key_store #(
    parameter int ENTRIES = rdf_pkg::DEF_ENTRIES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [$clog2(ENTRIES)-1:0]  i_waddr,
    input  wire rdf_pkg::t_key               i_wdata,
    input  wire logic                        i_re,
    input  wire logic [$clog2(ENTRIES)-1:0]  i_raddr,
    output rdf_pkg::t_key                    o_rdata
);
    import rdf_pkg::*;

    t_key r_mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/rdf_checker.sv
// ----------------------------------------------------------------------------
// rdf_checker
// Port-level checks of the duplicate filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rdf_checker (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_in_valid,
    input wire logic                     i_in_ready,
    input wire logic [rdf_pkg::CMD_W-1:0] i_in_cmd,
    input wire logic                     i_out_valid,
    input wire logic                     i_out_ready,
    input wire logic                     i_out_is_new
);
    import rdf_pkg::*;

    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    // a check keeps the input closed while the ring is walked
    `RDF_ASSERT_NEXT(a_check_blocks, i_clk, i_rst_n, in_acc && (i_in_cmd == CMD_CHECK), !i_in_ready)

    // a clear finishes at once and gives no result
    `RDF_ASSERT_NEXT(a_clear_quick, i_clk, i_rst_n, in_acc && (i_in_cmd == CMD_CLEAR), i_in_ready)

    // held result stays put under stall
    `RDF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_is_new))

endmodule

bind raw_result_duplicate_filter_top rdf_checker u_rdf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_cmd     (i_in.cmd),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_is_new (o_out.is_new)
);

`default_nettype wire

### verif/raw_result_duplicate_filter_top_tb.sv
// ----------------------------------------------------------------------------
// raw_result_duplicate_filter_top_tb
// Drives check and clear items into the duplicate filter. An in-bench
// predictor keeps its own ring of keys and expects one verdict per check.
// The bench compares each verdict with the oldest expected one. Random
// stalls on both channels, with a stretch of full throughput.
// ----------------------------------------------------------------------------
`default_nettype none

module raw_result_duplicate_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rdf_pkg::*;

    localparam int ENTRIES = DEF_ENTRIES;
    localparam int PTR_W   = $clog2(ENTRIES);

    typedef struct {
        logic [CMD_W-1:0] cmd;
        t_key             key;
    } t_filter_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rdf_in_if  in_ch ();
    rdf_out_if out_ch ();

    raw_result_duplicate_filter_top #(
        .ENTRIES (ENTRIES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #2 i_clk = ~i_clk;

    // predictor state: keys, live bits and the insert slot
    t_key             seen_key  [ENTRIES];
    bit               seen_live [ENTRIES];
    logic [PTR_W-1:0] insert_slot;

    t_filter_item item_q[$];
    logic         verdict_q[$];
    t_key         recent_keys[$];
    t_filter_item next_item;
    logic         want_new;
    int           fault_count;
    int           cycle_count;

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("mismatch: %s", msg);
        end
    endtask

    // one check gives a verdict, a clear only empties the ring
    task automatic screen_key(input logic [CMD_W-1:0] cmd, input t_key key);
        bit hit;
        hit = 1'b0;
        if (cmd == CMD_CLEAR) begin
            foreach (seen_live[i]) seen_live[i] = 1'b0;
            insert_slot = '0;
            return;
        end
        foreach (seen_live[i]) begin
            if (seen_live[i] && seen_key[i] == key) hit = 1'b1;
        end
        if (!hit) begin
            seen_key[insert_slot]  = key;
            seen_live[insert_slot] = 1'b1;
            insert_slot = (insert_slot == PTR_W'(ENTRIES - 1)) ? '0 : insert_slot + 1'b1;
        end
        verdict_q.push_back(!hit);
    endtask

    // no gaps over a middle stretch of the run
    function automatic bit want_gap();
        if (cycle_count >= 8000 && cycle_count < 16000) return 1'b0;
        return $urandom_range(99) < 6;
    endfunction

    function automatic t_key rand_key();
        t_key k;
        k.job_id   = JOB_W'($urandom);
        k.nonce    = $urandom;
        k.ver_roll = $urandom;
        k.hist_rev = $urandom;
        return k;
    endfunction

    task automatic queue_item(input logic [CMD_W-1:0] cmd, input t_key key);
        t_filter_item it;
        it.cmd = cmd;
        it.key = key;
        item_q.push_back(it);
        if (cmd == CMD_CHECK) begin
            recent_keys.push_back(key);
            if (recent_keys.size() > 48) void'(recent_keys.pop_front());
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) cycle_count <= 0;
        else cycle_count <= cycle_count + 1;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                screen_key(in_ch.cmd, t_key'{in_ch.job_id, in_ch.nonce,
                                             in_ch.ver_roll, in_ch.hist_rev});
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (item_q.size() > 0 && !want_gap()) begin
                    next_item = item_q.pop_front();
                    in_ch.cmd      <= next_item.cmd;
                    in_ch.job_id   <= next_item.key.job_id;
                    in_ch.nonce    <= next_item.key.nonce;
                    in_ch.ver_roll <= next_item.key.ver_roll;
                    in_ch.hist_rev <= next_item.key.hist_rev;
                    in_ch.valid    <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (verdict_q.size() == 0) begin
                    report_fault($sformatf("verdict is_new=%b with none expected",
                                           out_ch.is_new));
                end else begin
                    want_new = verdict_q.pop_front();
                    if (out_ch.is_new !== want_new) begin
                        report_fault($sformatf("is_new expected %b actual %b",
                                               want_new, out_ch.is_new));
                    end
                end
            end
            out_ch.ready <= !want_gap();
        end
    end

    initial begin
        #3ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_key base;
        t_key ones;
        t_key k;
        int   pick;
        int   field;

        fault_count = 0;
        insert_slot = '0;
        foreach (seen_live[i]) seen_live[i] = 1'b0;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.cmd      = CMD_CHECK;
        in_ch.job_id   = '0;
        in_ch.nonce    = '0;
        in_ch.ver_roll = '0;
        in_ch.hist_rev = '0;
        out_ch.ready   = 1'b0;

        // directed: extremes, duplicates, single-field differences, clears
        base = '0;
        ones = '1;
        queue_item(CMD_CHECK, base);
        queue_item(CMD_CHECK, ones);
        queue_item(CMD_CHECK, base);
        queue_item(CMD_CHECK, ones);
        k = base; k.job_id = '1;   queue_item(CMD_CHECK, k);
        k = base; k.nonce = '1;    queue_item(CMD_CHECK, k);
        k = base; k.ver_roll = '1; queue_item(CMD_CHECK, k);
        k = base; k.hist_rev = '1; queue_item(CMD_CHECK, k);
        k = ones; k.job_id = '0;   queue_item(CMD_CHECK, k);
        queue_item(CMD_CHECK, k);
        queue_item(CMD_CLEAR, rand_key());
        queue_item(CMD_CHECK, base);
        queue_item(CMD_CHECK, ones);
        queue_item(CMD_CHECK, base);
        queue_item(CMD_CLEAR, ones);
        queue_item(CMD_CLEAR, base);
        queue_item(CMD_CHECK, ones);
        queue_item(CMD_CHECK, ones);

        // random: repeats of recent keys, near misses, fresh keys, rare clears
        repeat (1000) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                queue_item(CMD_CLEAR, rand_key());
            end else if (pick < 43 && recent_keys.size() > 0) begin
                queue_item(CMD_CHECK, recent_keys[$urandom_range(recent_keys.size() - 1)]);
            end else if (pick < 63 && recent_keys.size() > 0) begin
                k = recent_keys[$urandom_range(recent_keys.size() - 1)];
                field = $urandom_range(3);
                case (field)
                    0: k.job_id[$urandom_range(JOB_W - 1)] ^= 1'b1;
                    1: k.nonce[$urandom_range(WORD_W - 1)] ^= 1'b1;
                    2: k.ver_roll[$urandom_range(WORD_W - 1)] ^= 1'b1;
                    default: k.hist_rev[$urandom_range(WORD_W - 1)] ^= 1'b1;
                endcase
                queue_item(CMD_CHECK, k);
            end else begin
                queue_item(CMD_CHECK, rand_key());
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (item_q.size() != 0 || in_ch.valid !== 1'b0) @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (ENTRIES + 16) @(posedge i_clk);

        if (verdict_q.size() != 0) begin
            report_fault($sformatf("%0d verdicts never arrived", verdict_q.size()));
        end
        if (fault_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
